/* design/dcmppt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcmppt_pkg
// Shared types and constants for the dual-channel perturb-and-observe tracker.
// ----------------------------------------------------------------------------
package dcmppt_pkg;

	localparam int VoltW    = 16;
	localparam int CurrW    = 16;
	localparam int PowW     = 20;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 19;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_CURRENT_LIMIT    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MINIMUM_VOLTAGE  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SMALL_POWER_BAND = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LARGE_POWER_BAND = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_COARSE_STEP      = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_FINE_STEP        = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_FAST_SEARCH_GAIN = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_CURRENT_MARGIN   = 3'd7;

	typedef struct packed {
		logic [14:0] current_limit;
		logic [14:0] minimum_voltage;
		logic [18:0] small_power_band;
		logic [18:0] large_power_band;
		logic [11:0] coarse_step;
		logic [11:0] fine_step;
		logic [18:0] fast_search_gain;
		logic [14:0] current_margin;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		current_limit:    15'd3840,
		minimum_voltage:  15'd2560,
		small_power_band: 19'd32,
		large_power_band: 19'd160,
		coarse_step:      12'd64,
		fine_step:        12'd16,
		fast_search_gain: 19'd80,
		current_margin:   15'd128
	};

	// pipeline stage controls from the top level to the lanes and the merge
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic adv_s3;
		logic upd;
	} pipe_ctl_t;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**22
	localparam logic [22:0] RECIP_100   = 23'd5368710;
	localparam int          RECIP_SHIFT = 29;

	localparam logic [9:0] VOLT_30V = 10'd960;

endpackage
`default_nettype wire

/* design/dcmppt_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcmppt_lane
// One tracker channel: seed division stages, P&O state and reference update.
// ----------------------------------------------------------------------------
module dcmppt_lane import dcmppt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  cfg_t                    cfg,
	input  logic                    run,
	input  logic signed [VoltW-1:0] volt,
	input  logic signed [CurrW-1:0] curr,
	input  logic signed [PowW-1:0]  power,
	output logic signed [VoltW-1:0] ref_next,
	output logic                    active_next
);

	localparam logic signed [17:0] SAT_MAX = 18'sd32767;
	localparam logic signed [17:0] SAT_MIN = -18'sd32768;

	// stage 1: sample and rounding numerators
	logic                    run_s1;
	logic signed [VoltW-1:0] volt_s1;
	logic signed [CurrW-1:0] curr_s1;
	logic signed [PowW-1:0]  power_s1;
	logic [21:0]             num_ref_s1;
	logic [15:0]             num_step_s1;

	// stage 2: sample and quotients
	logic                    run_s2;
	logic signed [VoltW-1:0] volt_s2;
	logic signed [CurrW-1:0] curr_s2;
	logic signed [PowW-1:0]  power_s2;
	logic [14:0]             q_ref_s2;
	logic [8:0]              q_step_s2;

	logic [44:0] prod_ref;
	logic [38:0] prod_step;

	// tracker state
	logic signed [VoltW-1:0] ref_q;
	logic [VoltW-1:0]        ocv_q;
	logic signed [PowW-1:0]  pp_q;
	logic [11:0]             step_q;
	logic                    down_q;
	logic                    on_q;
	logic                    fast_q;

	logic signed [VoltW-1:0] ref_d;
	logic [VoltW-1:0]        ocv_d;
	logic signed [PowW-1:0]  pp_d;
	logic [11:0]             step_d;
	logic                    down_d;
	logic                    on_d;
	logic                    fast_d;

	logic                    bad;
	logic [11:0]             step_use;
	logic [11:0]             seed_step;
	logic signed [21:0]      delta;
	logic signed [21:0]      gain;
	logic signed [21:0]      band;
	logic                    rise_fast;
	logic                    rise;
	logic                    fall;
	logic [15:0]             lim_sum;
	logic                    over;
	logic signed [17:0]      r0, r1, r2, r3, r4, r5;
	logic signed [17:0]      stepx, coarse, fine, vext, vlim, minv, ocv_ext;
	logic                    down_new;
	logic                    fast_new;
	logic signed [VoltW-1:0] ref_trk;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			run_s1      <= run;
			volt_s1     <= volt;
			curr_s1     <= curr;
			power_s1    <= power;
			num_ref_s1  <= {7'd0, volt[14:0]} * 22'd98 + 22'd50;
			num_step_s1 <= {1'b0, volt[14:0]} + 16'd50;
		end
	end

	assign prod_ref  = {23'd0, num_ref_s1} * {22'd0, RECIP_100};
	assign prod_step = {23'd0, num_step_s1} * {16'd0, RECIP_100};

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			run_s2    <= run_s1;
			volt_s2   <= volt_s1;
			curr_s2   <= curr_s1;
			power_s2  <= power_s1;
			q_ref_s2  <= prod_ref[RECIP_SHIFT +: 15];
			q_step_s2 <= prod_step[RECIP_SHIFT +: 9];
		end
	end

	// tracking step
	assign bad       = !run_s2 || (volt_s2 <= 16'sd0) || (curr_s2 <= 16'sd0);
	assign step_use  = (step_q < cfg.coarse_step) ? cfg.coarse_step : step_q;
	assign seed_step = ({3'd0, q_step_s2} < cfg.coarse_step) ? cfg.coarse_step
	                                                         : {3'd0, q_step_s2};
	assign delta     = {{2{power_s2[PowW-1]}}, power_s2} - {{2{pp_q[PowW-1]}}, pp_q};
	assign gain      = {3'd0, cfg.fast_search_gain};
	assign band      = {3'd0, cfg.small_power_band};
	assign rise_fast = delta > gain;
	assign rise      = delta > band;
	assign fall      = (delta + band) < 22'sd0;
	assign lim_sum   = {1'b0, cfg.current_limit} + {1'b0, cfg.current_margin};
	assign over      = {{2{curr_s2[CurrW-1]}}, curr_s2} > {2'b00, lim_sum};

	assign r0      = {{2{ref_q[VoltW-1]}}, ref_q};
	assign stepx   = {6'd0, step_use};
	assign coarse  = {6'd0, cfg.coarse_step};
	assign fine    = {6'd0, cfg.fine_step};
	assign vext    = {{2{volt_s2[VoltW-1]}}, volt_s2};
	assign vlim    = vext + {8'd0, VOLT_30V};
	assign minv    = {3'd0, cfg.minimum_voltage};
	assign ocv_ext = {2'b00, ocv_q};

	always_comb begin
		down_new = down_q;
		fast_new = fast_q;
		r1       = r0;
		if (fast_q) begin
			if (rise_fast) begin
				r1 = r0 - stepx;
			end else begin
				r1       = r0 + coarse;
				fast_new = 1'b0;
			end
		end else if (rise) begin
			r1 = down_q ? r0 - stepx : r0 + stepx;
		end else if (fall) begin
			down_new = !down_q;
			r1       = down_q ? r0 + stepx : r0 - stepx;
		end else begin
			r1 = down_q ? r0 - fine : r0 + fine;
		end
	end

	assign r2 = over ? r1 + coarse : r1;
	assign r3 = (r2 > vlim) ? vext - coarse : r2;
	assign r4 = (r3 < minv) ? minv : r3;
	assign r5 = ((ocv_ext >= minv) && (r4 > ocv_ext)) ? ocv_ext : r4;

	always_comb begin
		if (r5 > SAT_MAX) begin
			ref_trk = SAT_MAX[VoltW-1:0];
		end else if (r5 < SAT_MIN) begin
			ref_trk = SAT_MIN[VoltW-1:0];
		end else begin
			ref_trk = r5[VoltW-1:0];
		end
	end

	always_comb begin
		ref_d  = ref_q;
		ocv_d  = ocv_q;
		pp_d   = pp_q;
		step_d = step_q;
		down_d = down_q;
		on_d   = on_q;
		fast_d = fast_q;
		if (bad) begin
			ref_d  = '0;
			ocv_d  = '0;
			pp_d   = '0;
			step_d = cfg.coarse_step;
			down_d = 1'b1;
			on_d   = 1'b0;
			fast_d = 1'b1;
		end else if (!on_q) begin
			// first good sample seeds just below open circuit
			ref_d  = {1'b0, q_ref_s2};
			ocv_d  = volt_s2;
			pp_d   = power_s2;
			step_d = seed_step;
			down_d = 1'b1;
			on_d   = 1'b1;
			fast_d = 1'b1;
		end else begin
			ref_d  = ref_trk;
			pp_d   = power_s2;
			down_d = down_new;
			fast_d = fast_new;
		end
	end

	assign ref_next    = ref_d;
	assign active_next = on_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			ocv_q  <= '0;
			pp_q   <= '0;
			step_q <= CFG_RESET.coarse_step;
			down_q <= 1'b1;
			on_q   <= 1'b0;
			fast_q <= 1'b1;
		end else if (ctl.upd) begin
			ref_q  <= ref_d;
			ocv_q  <= ocv_d;
			pp_q   <= pp_d;
			step_q <= step_d;
			down_q <= down_d;
			on_q   <= on_d;
			fast_q <= fast_d;
		end
	end

endmodule
`default_nettype wire

/* design/dcmppt_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcmppt_merge
// Output register: joins both lanes' results and forms the input mode.
// ----------------------------------------------------------------------------
module dcmppt_merge import dcmppt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  logic signed [VoltW-1:0] ref1,
	input  logic                    act1,
	input  logic signed [VoltW-1:0] ref2,
	input  logic                    act2,
	output logic                    result_valid,
	output logic signed [VoltW-1:0] pv1_reference,
	output logic                    pv1_active,
	output logic signed [VoltW-1:0] pv2_reference,
	output logic                    pv2_active,
	output logic [1:0]              input_mode
);

	logic                    valid_q;
	logic signed [VoltW-1:0] ref1_q;
	logic signed [VoltW-1:0] ref2_q;
	logic                    act1_q;
	logic                    act2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.adv_s3) begin
			valid_q <= ctl.upd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			ref1_q <= ref1;
			ref2_q <= ref2;
			act1_q <= act1;
			act2_q <= act2;
		end
	end

	assign result_valid  = valid_q;
	assign pv1_reference = ref1_q;
	assign pv1_active    = act1_q;
	assign pv2_reference = ref2_q;
	assign pv2_active    = act2_q;
	assign input_mode    = {act2_q, act1_q};

endmodule
`default_nettype wire

/* design/dual_channel_mppt_perturb_observe.sv */
// Item to result: stage 1, stage 2 and output registers in that order.
// Throughput: one item per cycle without back-pressure; each lane updates
// its tracker state at the output register after two /100 seeding stages.
// Reset (arst_n low): pipeline emptied, registers at their defaults, both
// trackers disabled with zero reference.
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_mppt_perturb_observe
// Two-lane perturb-and-observe MPPT with pipeline control and register file.
// ----------------------------------------------------------------------------
module dual_channel_mppt_perturb_observe import dcmppt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// item channel
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    run,
	input  logic signed [VoltW-1:0] pv1_volt,
	input  logic signed [CurrW-1:0] pv1_curr,
	input  logic signed [PowW-1:0]  pv1_power,
	input  logic signed [VoltW-1:0] pv2_volt,
	input  logic signed [CurrW-1:0] pv2_curr,
	input  logic signed [PowW-1:0]  pv2_power,
	// result channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [VoltW-1:0] pv1_reference,
	output logic                    pv1_active,
	output logic signed [VoltW-1:0] pv2_reference,
	output logic                    pv2_active,
	output logic [1:0]              input_mode,
	// configuration
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIdxW-1:0]      cfg_index,
	input  logic [CfgDataW-1:0]     cfg_data
);

	cfg_t      cfg_q;
	pipe_ctl_t ctl;
	logic      vld_s1;
	logic      vld_s2;
	logic      en1, en2, en3;

	logic signed [VoltW-1:0] ref1, ref2;
	logic                    act1, act2;

	// each stage moves when it is empty or the one after it moves
	assign en3 = !result_valid || !result_stall;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign item_stall = !en1;
	assign ctl.ld_s1  = en1;
	assign ctl.ld_s2  = en2;
	assign ctl.adv_s3 = en3;
	assign ctl.upd    = vld_s2 && en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= item_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CURRENT_LIMIT:    cfg_q.current_limit    <= cfg_data[14:0];
				CFG_MINIMUM_VOLTAGE:  cfg_q.minimum_voltage  <= cfg_data[14:0];
				CFG_SMALL_POWER_BAND: cfg_q.small_power_band <= cfg_data[18:0];
				CFG_LARGE_POWER_BAND: cfg_q.large_power_band <= cfg_data[18:0];
				CFG_COARSE_STEP:      cfg_q.coarse_step      <= cfg_data[11:0];
				CFG_FINE_STEP:        cfg_q.fine_step        <= cfg_data[11:0];
				CFG_FAST_SEARCH_GAIN: cfg_q.fast_search_gain <= cfg_data[18:0];
				CFG_CURRENT_MARGIN:   cfg_q.current_margin   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	dcmppt_lane u_lane1 (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.run         (run),
		.volt        (pv1_volt),
		.curr        (pv1_curr),
		.power       (pv1_power),
		.ref_next    (ref1),
		.active_next (act1)
	);

	dcmppt_lane u_lane2 (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.run         (run),
		.volt        (pv2_volt),
		.curr        (pv2_curr),
		.power       (pv2_power),
		.ref_next    (ref2),
		.active_next (act2)
	);

	dcmppt_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.ref1          (ref1),
		.act1          (act1),
		.ref2          (ref2),
		.act2          (act2),
		.result_valid  (result_valid),
		.pv1_reference (pv1_reference),
		.pv1_active    (pv1_active),
		.pv2_reference (pv2_reference),
		.pv2_active    (pv2_active),
		.input_mode    (input_mode)
	);

endmodule
`default_nettype wire

/* design/dcmppt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dcmppt_checker
// Port-level checks on the result channel of the tracker.
// ----------------------------------------------------------------------------
module dcmppt_checker import dcmppt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    result_valid,
	input logic                    result_stall,
	input logic signed [VoltW-1:0] pv1_reference,
	input logic                    pv1_active,
	input logic signed [VoltW-1:0] pv2_reference,
	input logic                    pv2_active,
	input logic [1:0]              input_mode
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pv1_reference)
		&& $stable(pv2_reference) && $stable(input_mode))
		else $error("result beat changed under stall");

	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> input_mode == {pv2_active, pv1_active})
		else $error("input mode disagrees with channel flags");

	// a disabled channel reports zero reference
	a_idle1: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pv1_active |-> pv1_reference == '0)
		else $error("channel 1 idle with non-zero reference");

	a_idle2: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pv2_active |-> pv2_reference == '0)
		else $error("channel 2 idle with non-zero reference");

endmodule

bind dual_channel_mppt_perturb_observe dcmppt_checker u_dcmppt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.pv1_reference (pv1_reference),
	.pv1_active    (pv1_active),
	.pv2_reference (pv2_reference),
	.pv2_active    (pv2_active),
	.input_mode    (input_mode)
);
`default_nettype wire

/* tb/sv/tb_dual_channel_mppt_perturb_observe.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_channel_mppt_perturb_observe
// Drives sample beats through both PV trackers and predicts every result beat
// (references, enables, input mode) from a behavioural copy of the tracker
// state. A short hand-written sequence is followed by randomised tracking
// sessions under five register settings and three handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_dual_channel_mppt_perturb_observe;
	import dcmppt_pkg::*;

	typedef struct {
		logic                    run;
		logic signed [VoltW-1:0] v1;
		logic signed [CurrW-1:0] i1;
		logic signed [PowW-1:0]  p1;
		logic signed [VoltW-1:0] v2;
		logic signed [CurrW-1:0] i2;
		logic signed [PowW-1:0]  p2;
	} pv_sample_t;

	typedef struct {
		logic signed [VoltW-1:0] ref1;
		logic                    act1;
		logic signed [VoltW-1:0] ref2;
		logic                    act2;
		logic [1:0]              mode;
	} setpoint_t;

	typedef struct {
		int ref_v;
		int voc;
		int last_pow;
		int step_sz;
		bit going_down;
		bit tracking;
		bit fast;
	} pv_track_t;

	typedef enum int {SET_FLOOR, SET_CEILING, SET_SCRAMBLED, SET_TYPICAL, SET_DEFAULT} setting_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic run = 1'b0;
	logic signed [VoltW-1:0] pv1_volt = '0;
	logic signed [CurrW-1:0] pv1_curr = '0;
	logic signed [PowW-1:0]  pv1_power = '0;
	logic signed [VoltW-1:0] pv2_volt = '0;
	logic signed [CurrW-1:0] pv2_curr = '0;
	logic signed [PowW-1:0]  pv2_power = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [VoltW-1:0] pv1_reference;
	logic pv1_active;
	logic signed [VoltW-1:0] pv2_reference;
	logic pv2_active;
	logic [1:0] input_mode;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	dual_channel_mppt_perturb_observe dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .run(run),
		.pv1_volt(pv1_volt), .pv1_curr(pv1_curr), .pv1_power(pv1_power),
		.pv2_volt(pv2_volt), .pv2_curr(pv2_curr), .pv2_power(pv2_power),
		.result_valid(result_valid), .result_stall(result_stall),
		.pv1_reference(pv1_reference), .pv1_active(pv1_active),
		.pv2_reference(pv2_reference), .pv2_active(pv2_active),
		.input_mode(input_mode),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pv_sample_t sample_q[$];
	setpoint_t  setpoint_q[$];
	pv_sample_t on_wire;
	cfg_t       regs = CFG_RESET;
	pv_track_t  trk[2];
	int sess_v[2] = '{0, 0};
	int sess_p[2] = '{0, 0};
	int send_idle_pct = 10;
	int recv_stall_pct = 76;
	int hold_left = 0;
	int mismatches = 0;
	int beats = 0;

	initial forever #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_dual_channel_mppt_perturb_observe: errors");
		$finish;
	end

	task automatic flag(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// ---- tracker prediction ----
	function automatic void track_clear(int k);
		trk[k].ref_v = 0;
		trk[k].voc = 0;
		trk[k].last_pow = 0;
		trk[k].step_sz = int'(regs.coarse_step);
		trk[k].going_down = 1'b1;
		trk[k].tracking = 1'b0;
		trk[k].fast = 1'b1;
	endfunction

	function automatic void track_update(int k, int v, int i, int p);
		int stp, dlt, r, cstep, minv, fine, band;
		cstep = int'(regs.coarse_step);
		minv = int'(regs.minimum_voltage);
		fine = int'(regs.fine_step);
		band = int'(regs.small_power_band);
		if (v <= 0 || i <= 0) begin
			track_clear(k);
			return;
		end
		if (!trk[k].tracking) begin
			// seed just below open circuit, ties round up
			trk[k].voc = v;
			trk[k].ref_v = (v * 98 + 50) / 100;
			trk[k].step_sz = ((v + 50) / 100 < cstep) ? cstep : (v + 50) / 100;
			trk[k].last_pow = p;
			trk[k].going_down = 1'b1;
			trk[k].fast = 1'b1;
			trk[k].tracking = 1'b1;
			return;
		end
		stp = (trk[k].step_sz < cstep) ? cstep : trk[k].step_sz;
		dlt = p - trk[k].last_pow;
		r = trk[k].ref_v;
		if (trk[k].fast) begin
			if (dlt > int'(regs.fast_search_gain)) begin
				r -= stp;
			end else begin
				r += cstep;
				trk[k].fast = 1'b0;
			end
		end else if (dlt > band) begin
			r += trk[k].going_down ? -stp : stp;
		end else if (dlt < -band) begin
			trk[k].going_down = !trk[k].going_down;
			r += trk[k].going_down ? -stp : stp;
		end else begin
			r += trk[k].going_down ? -fine : fine;
		end
		if (i > int'(regs.current_limit) + int'(regs.current_margin))
			r += cstep;
		if (r > v + int'(VOLT_30V))
			r = v - cstep;
		if (r < minv)
			r = minv;
		if (trk[k].voc >= minv && r > trk[k].voc)
			r = trk[k].voc;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		trk[k].ref_v = r;
		trk[k].last_pow = p;
	endfunction

	function automatic void mppt_predict(pv_sample_t s);
		setpoint_t e;
		if (!s.run) begin
			track_clear(0);
			track_clear(1);
		end else begin
			track_update(0, int'(s.v1), int'(s.i1), int'(s.p1));
			track_update(1, int'(s.v2), int'(s.i2), int'(s.p2));
		end
		e.ref1 = 16'(trk[0].ref_v);
		e.act1 = trk[0].tracking;
		e.ref2 = 16'(trk[1].ref_v);
		e.act2 = trk[1].tracking;
		e.mode = {trk[1].tracking, trk[0].tracking};
		setpoint_q.push_back(e);
	endfunction

	function automatic void reg_store(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
		case (idx)
			CFG_CURRENT_LIMIT:    regs.current_limit = d[14:0];
			CFG_MINIMUM_VOLTAGE:  regs.minimum_voltage = d[14:0];
			CFG_SMALL_POWER_BAND: regs.small_power_band = d[18:0];
			CFG_LARGE_POWER_BAND: regs.large_power_band = d[18:0];
			CFG_COARSE_STEP:      regs.coarse_step = d[11:0];
			CFG_FINE_STEP:        regs.fine_step = d[11:0];
			CFG_FAST_SEARCH_GAIN: regs.fast_search_gain = d[18:0];
			default:              regs.current_margin = d[14:0];
		endcase
	endfunction

	// ---- stimulus helpers ----
	function automatic pv_sample_t mk_beat(bit r, int v1, int i1, int p1,
			int v2, int i2, int p2);
		pv_sample_t s;
		s.run = r;
		s.v1 = 16'(v1);
		s.i1 = 16'(i1);
		s.p1 = 20'(p1);
		s.v2 = 16'(v2);
		s.i2 = 16'(i2);
		s.p2 = 20'(p2);
		return s;
	endfunction

	function automatic void draw_channel(int k, output int v, output int i, output int p);
		int r, sel, span;
		r = $urandom_range(99);
		if (r < 4) begin
			v = int'($signed(16'($urandom())));
			i = int'($signed(16'($urandom())));
			p = int'($signed(20'($urandom())));
		end else if (r < 9) begin
			// broken sample: one of voltage or current non-positive
			v = (sess_v[k] > 0) ? sess_v[k] : 1000;
			i = $urandom_range(1, 5000);
			p = sess_p[k];
			if ($urandom_range(1))
				v = -int'($urandom_range(32768));
			else
				i = -int'($urandom_range(32768));
		end else begin
			if (r < 14 || sess_v[k] == 0) begin
				sess_v[k] = $urandom_range(1, 32767);
				sess_p[k] = int'($urandom_range(300000)) - 50000;
			end
			sel = $urandom_range(3);
			span = (sel == 0) ? 40 : (sel == 1) ? 200 : (sel == 2) ? 3000 : 200000;
			sess_p[k] += int'($urandom_range(2 * span)) - span;
			if (sess_p[k] > 524287)
				sess_p[k] = 524287;
			if (sess_p[k] < -524288)
				sess_p[k] = -524288;
			v = sess_v[k] + int'($urandom_range(1200)) - 600;
			if (v < 1)
				v = 1;
			if (v > 32767)
				v = 32767;
			if ($urandom_range(19) == 0)
				v = $urandom_range(1, 32767);
			i = ($urandom_range(9) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 5000);
			p = sess_p[k];
		end
	endfunction

	function automatic pv_sample_t draw_sample();
		int v1, i1, p1, v2, i2, p2;
		draw_channel(0, v1, i1, p1);
		draw_channel(1, v2, i2, p2);
		return mk_beat($urandom_range(99) >= 3, v1, i1, p1, v2, i2, p2);
	endfunction

	task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_store(idx, d);
	endtask

	task automatic load_setting(input setting_e which);
		logic [CfgIdxW-1:0] idx;
		logic [CfgDataW-1:0] d;
		for (int n = 0; n < 8; n++) begin
			idx = CfgIdxW'(n);
			case (which)
				SET_FLOOR:     d = '0;
				SET_CEILING:   d = '1;
				SET_SCRAMBLED: d = CfgDataW'($urandom());
				SET_TYPICAL: begin
					case (idx)
						CFG_CURRENT_LIMIT:    d = CfgDataW'($urandom_range(1000, 6000));
						CFG_MINIMUM_VOLTAGE:  d = CfgDataW'($urandom_range(8000));
						CFG_SMALL_POWER_BAND: d = CfgDataW'($urandom_range(100));
						CFG_LARGE_POWER_BAND: d = CfgDataW'($urandom_range(524287));
						CFG_COARSE_STEP:      d = CfgDataW'($urandom_range(1, 200));
						CFG_FINE_STEP:        d = CfgDataW'($urandom_range(100));
						CFG_FAST_SEARCH_GAIN: d = CfgDataW'($urandom_range(400));
						default:              d = CfgDataW'($urandom_range(500));
					endcase
				end
				default: begin
					case (idx)
						CFG_CURRENT_LIMIT:    d = CfgDataW'(CFG_RESET.current_limit);
						CFG_MINIMUM_VOLTAGE:  d = CfgDataW'(CFG_RESET.minimum_voltage);
						CFG_SMALL_POWER_BAND: d = CfgDataW'(CFG_RESET.small_power_band);
						CFG_LARGE_POWER_BAND: d = CfgDataW'(CFG_RESET.large_power_band);
						CFG_COARSE_STEP:      d = CfgDataW'(CFG_RESET.coarse_step);
						CFG_FINE_STEP:        d = CfgDataW'(CFG_RESET.fine_step);
						CFG_FAST_SEARCH_GAIN: d = CfgDataW'(CFG_RESET.fast_search_gain);
						default:              d = CfgDataW'(CFG_RESET.current_margin);
					endcase
				end
			endcase
			reg_write(idx, d);
		end
	endtask

	// wait for every queued beat to go in and every result to come back
	task automatic settle(input int tail);
		while (sample_q.size() != 0 || item_valid || setpoint_q.size() != 0)
			@(negedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// ---- sample driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				mppt_predict(on_wire);
			if (!item_valid || !item_stall) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = sample_q.pop_front();
					item_valid <= 1'b1;
					run <= on_wire.run;
					pv1_volt <= on_wire.v1;
					pv1_curr <= on_wire.i1;
					pv1_power <= on_wire.p1;
					pv2_volt <= on_wire.v2;
					pv2_curr <= on_wire.i2;
					pv2_power <= on_wire.p2;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---- result back-pressure ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ---- result checker ----
	always @(posedge clk) begin
		setpoint_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (setpoint_q.size() == 0) begin
				flag($sformatf("beat %0d: result with nothing outstanding", beats));
			end else begin
				e = setpoint_q.pop_front();
				if (pv1_reference !== e.ref1)
					flag($sformatf("beat %0d pv1_reference %0d, want %0d",
						beats, pv1_reference, e.ref1));
				if (pv1_active !== e.act1)
					flag($sformatf("beat %0d pv1_active %b, want %b", beats, pv1_active, e.act1));
				if (pv2_reference !== e.ref2)
					flag($sformatf("beat %0d pv2_reference %0d, want %0d",
						beats, pv2_reference, e.ref2));
				if (pv2_active !== e.act2)
					flag($sformatf("beat %0d pv2_active %b, want %b", beats, pv2_active, e.act2));
				if (input_mode !== e.mode)
					flag($sformatf("beat %0d input_mode %0d, want %0d", beats, input_mode, e.mode));
			end
			beats++;
		end
	end

	// ---- sequence ----
	initial begin
		track_clear(0);
		track_clear(1);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// hand-written walk through the tracker under reset registers
		sample_q.push_back(mk_beat(0, 0, 0, 0, 0, 0, 0));
		sample_q.push_back(mk_beat(1, 0, 100, 100, -1, 100, 100));
		sample_q.push_back(mk_beat(1, 1000, 0, 100, 1000, -32768, 100));
		sample_q.push_back(mk_beat(1, 20000, 2000, 1000, 32767, 32767, 524287));
		sample_q.push_back(mk_beat(1, 19700, 2000, 1200, 32767, 32767, 524287));
		sample_q.push_back(mk_beat(1, 19500, 2000, 1250, 32767, 32767, -524288));
		sample_q.push_back(mk_beat(1, 19500, 2000, 1300, 32767, 32767, 524287));
		sample_q.push_back(mk_beat(1, 19500, 2000, 1200, 32767, 100, 524287));
		sample_q.push_back(mk_beat(1, 19500, 2000, 1210, 32767, 100, 524280));
		sample_q.push_back(mk_beat(1, 19500, 3969, 1210, 32767, 3968, 524280));
		sample_q.push_back(mk_beat(1, 19500, 3968, 1210, 32767, 3969, 524280));
		sample_q.push_back(mk_beat(1, 1000, 2000, 1210, 2000, 100, 0));
		sample_q.push_back(mk_beat(1, 32767, 2000, -524288, 32767, 100, 100));
		sample_q.push_back(mk_beat(1, 1, 1, -524288, -32768, -32768, -524288));
		sample_q.push_back(mk_beat(1, 1, 1, 524287, 1, 1, 0));
		sample_q.push_back(mk_beat(1, 1, 1, 524287, 1, 1, 40));
		sample_q.push_back(mk_beat(0, 32767, 32767, 524287, 32767, 32767, 524287));
		sample_q.push_back(mk_beat(1, 2560, 1, 5, 2561, 1, 5));
		sample_q.push_back(mk_beat(1, 2560, 1, -10, 2561, 1, 200));
		sample_q.push_back(mk_beat(1, 2600, 1, 300, 2561, 1, 200));
		settle(6);

		for (int seg = 0; seg < 5; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 10;
				recv_stall_pct = 76;
			end else if (seg < 4) begin
				send_idle_pct = 76;
				recv_stall_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			load_setting(setting_e'(seg));
			repeat (86) sample_q.push_back(draw_sample());
			if (seg == 0) begin
				// long hold on the result side so the pipe backs up into item_stall
				@(negedge clk);
				hold_left = 80;
			end
			settle(6);
		end

		settle(10);
		if (mismatches == 0)
			$display("tb_dual_channel_mppt_perturb_observe: clean");
		else
			$display("tb_dual_channel_mppt_perturb_observe: errors");
		$finish;
	end

endmodule

/* dual_channel_mppt_perturb_observe.f */
design/dcmppt_pkg.sv
design/dcmppt_lane.sv
design/dcmppt_merge.sv
design/dual_channel_mppt_perturb_observe.sv
design/dcmppt_checker.sv
tb/sv/tb_dual_channel_mppt_perturb_observe.sv
